/* design/maas_pkg.sv */
// Shared types and constants of the ADC average and scaling block.
package maas_pkg;

  localparam int unsigned CHANNELS  = 4;
  localparam int unsigned SAMPLE_W  = 12;
  localparam int unsigned CFG_W     = 12;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_W-1:0] VREF_CAL_RST  = 12'd1500;
  localparam logic [CFG_W-1:0] TEMP_LOW_RST  = 12'd940;
  localparam logic [CFG_W-1:0] TEMP_HIGH_RST = 12'd1200;

  localparam int unsigned MUL_W  = 32;
  localparam int unsigned PROD_W = 2 * MUL_W;
  localparam int unsigned PART_W = 2 * SAMPLE_W;

  // Battery: round(a * 485100 / 192465) = floor((64680 * a + 12831) / 25662)
  localparam int unsigned  MV_W      = 14;
  localparam logic [13:0]  MV_MAX    = 14'd10321;
  localparam int unsigned  BAT_MUL   = 64680;
  localparam int unsigned  BAT_ADD   = 12831;
  localparam int unsigned  BAT_DEN   = 25662;
  localparam int unsigned  BAT_SHIFT = 43;
  localparam logic [63:0]  BAT_RECIP =
    ((64'd1 << BAT_SHIFT) + 64'(BAT_DEN) - 64'd1) / 64'(BAT_DEN);

  // Temperature
  localparam int unsigned TEMP_W      = 16;
  localparam int unsigned TEMP_GAIN   = 8000;
  localparam int unsigned TEMP_OFFSET = 3000;
  localparam int unsigned QUO_W       = 16;
  localparam int unsigned CNT_W       = $clog2(QUO_W);
  localparam int unsigned NUM_W       = 42;
  localparam logic signed [TEMP_W-1:0] TEMP_MAX = 16'sh7FFF;
  localparam logic signed [TEMP_W-1:0] TEMP_MIN = 16'sh8000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_VREF_CAL  = 2'd0,
    CFG_TEMP_LOW  = 2'd1,
    CFG_TEMP_HIGH = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [CFG_W-1:0] vref_cal;
    logic [CFG_W-1:0] temp_low;
    logic [CFG_W-1:0] temp_high;
  } maas_cfg_t;

  typedef enum logic {
    FR_IDLE,
    FR_UPDATE
  } front_state_e;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_AVG0,
    BK_AVG1,
    BK_AVG2,
    BK_AVG3,
    BK_BAT0,
    BK_BAT1,
    BK_P1,
    BK_P2,
    BK_MD,
    BK_MN,
    BK_PREP,
    BK_CHK,
    BK_DIV,
    BK_FIN
  } back_state_e;

endpackage

/* design/maas_if.sv */
// Scan and result channel interfaces.
interface maas_in_if;
  import maas_pkg::*;
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] current_sample;
  logic [SAMPLE_W-1:0] battery_sample;
  logic [SAMPLE_W-1:0] temp_sample;
  logic [SAMPLE_W-1:0] vref_sample;

  modport source (output valid, current_sample, battery_sample, temp_sample, vref_sample,
                  input ready);
  modport sink   (input valid, current_sample, battery_sample, temp_sample, vref_sample,
                  output ready);
endinterface

interface maas_out_if;
  import maas_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [SAMPLE_W-1:0]      current_avg;
  logic [MV_W-1:0]          battery_millivolts;
  logic signed [TEMP_W-1:0] temp_centidegrees;
  logic                     temp_invalid;

  modport source (output valid, current_avg, battery_millivolts, temp_centidegrees,
                  temp_invalid, input ready);
  modport sink   (input valid, current_avg, battery_millivolts, temp_centidegrees,
                  temp_invalid, output ready);
endinterface

/* design/maas_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module maas_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 128,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* design/maas_front.sv */
// Front end: takes scans, updates the sample history and the window sums.
module maas_front #(
  parameter int unsigned WINDOW_DEPTH = 128,
  localparam int unsigned SUM_W = maas_pkg::SAMPLE_W + $clog2(WINDOW_DEPTH)
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  maas_in_if.sink                                    in_chan,
  output logic                                       push_valid_o,
  input  logic                                       push_ready_i,
  output logic [maas_pkg::CHANNELS-1:0][SUM_W-1:0]   push_sums_o
);
  import maas_pkg::*;

  localparam int unsigned SLOT_W = $clog2(WINDOW_DEPTH);

  front_state_e state_q, state_d;
  logic [CHANNELS-1:0][SAMPLE_W-1:0] samples_q;
  logic [CHANNELS-1:0][SAMPLE_W-1:0] rd_data;
  logic [CHANNELS-1:0][SAMPLE_W-1:0] old_sample;
  logic [CHANNELS-1:0][SUM_W-1:0]    sums_q, sums_d;
  logic [SLOT_W-1:0]                 slot_q;
  logic                              wrapped_q;
  logic                              last_slot;
  logic                              update;

  assign update        = (state_q == FR_UPDATE);
  assign last_slot     = (slot_q == SLOT_W'(WINDOW_DEPTH - 1));
  assign in_chan.ready = (state_q == FR_IDLE) && push_ready_i;
  assign push_valid_o  = update;
  assign push_sums_o   = sums_d;

  maas_ram #(
    .WIDTH (CHANNELS * SAMPLE_W),
    .DEPTH (WINDOW_DEPTH)
  ) u_history (
    .clk_i   (clk_i),
    .we_i    (update),
    .waddr_i (slot_q),
    .wdata_i (samples_q),
    .raddr_i (slot_q),
    .rdata_o (rd_data)
  );

  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      old_sample[c] = wrapped_q ? rd_data[c] : '0;
      sums_d[c] = sums_q[c] - SUM_W'(old_sample[c]) + SUM_W'(samples_q[c]);
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FR_IDLE: begin
        if (in_chan.valid && in_chan.ready) state_d = FR_UPDATE;
      end
      FR_UPDATE: state_d = FR_IDLE;
      default:   state_d = FR_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= FR_IDLE;
      sums_q    <= '0;
      slot_q    <= '0;
      wrapped_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (update) begin
        sums_q <= sums_d;
        slot_q <= last_slot ? '0 : slot_q + SLOT_W'(1);
        if (last_slot) wrapped_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_chan.valid && in_chan.ready) begin
      samples_q[0] <= in_chan.current_sample;
      samples_q[1] <= in_chan.battery_sample;
      samples_q[2] <= in_chan.temp_sample;
      samples_q[3] <= in_chan.vref_sample;
    end
  end

endmodule

/* design/maas_queue.sv */
// Two-entry queue of window sums between front and back end.
module maas_queue #(
  parameter int unsigned WIDTH = 76
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);

  logic [1:0][WIDTH-1:0] mem_q;
  logic                  wr_ptr_q, rd_ptr_q;
  logic [1:0]            count_q;
  logic                  push, pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      if (push && !pop)      count_q <= count_q + 2'd1;
      else if (pop && !push) count_q <= count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= push_data_i;
  end

endmodule

/* design/maas_back.sv */
// Back end: averages, battery scaling and temperature calibration on a shared
// multiplier and a shift-subtract divider.
module maas_back #(
  parameter int unsigned WINDOW_DEPTH = 128,
  localparam int unsigned SUM_W = maas_pkg::SAMPLE_W + $clog2(WINDOW_DEPTH)
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  maas_pkg::maas_cfg_t                      cfg_i,
  input  logic                                     pop_valid_i,
  output logic                                     pop_ready_o,
  input  logic [maas_pkg::CHANNELS-1:0][SUM_W-1:0] pop_sums_i,
  maas_out_if.source                               out_chan
);
  import maas_pkg::*;

  localparam int unsigned SLOT_W    = $clog2(WINDOW_DEPTH);
  localparam int unsigned AVG_SHIFT = SUM_W + SLOT_W;
  localparam logic [63:0] AVG_RECIP =
    ((64'd1 << AVG_SHIFT) + 64'(WINDOW_DEPTH) - 64'd1) / 64'(WINDOW_DEPTH);

  back_state_e state_q, state_d;

  logic [CHANNELS-1:0][SUM_W-1:0]    sums_q;
  logic [CHANNELS-1:0][SAMPLE_W-1:0] avg_q;
  logic [MUL_W-1:0]                  mul_a, mul_b;
  logic [PROD_W-1:0]                 prod_q;
  logic [MV_W-1:0]                   mv_q;
  logic [PART_W-1:0]                 p1_q, mag_q, md_q;
  logic                              neg_q, invalid_q, ovf_q;
  logic [NUM_W-1:0]                  num_q, den_q;
  logic [QUO_W-1:0]                  quo_q;
  logic [CNT_W-1:0]                  cnt_q;
  logic                              out_valid_q;
  logic                              out_free;

  logic signed [CFG_W:0]    span;
  logic [CFG_W-1:0]         abs_span;
  logic signed [PART_W:0]   diff;
  logic [PART_W-1:0]        abs_diff;
  logic [MUL_W-1:0]         bat_n;
  logic [NUM_W:0]           trial;
  logic signed [TEMP_W+1:0] temp_wide;
  logic signed [TEMP_W-1:0] temp_res;

  logic [SAMPLE_W-1:0]      avg_out_q;
  logic [MV_W-1:0]          mv_out_q;
  logic signed [TEMP_W-1:0] temp_out_q;
  logic                     invalid_out_q;

  assign pop_ready_o = (state_q == BK_IDLE);
  assign out_free    = !out_valid_q || out_chan.ready;

  assign out_chan.valid              = out_valid_q;
  assign out_chan.current_avg        = avg_out_q;
  assign out_chan.battery_millivolts = mv_out_q;
  assign out_chan.temp_centidegrees  = temp_out_q;
  assign out_chan.temp_invalid       = invalid_out_q;

  assign span     = $signed({1'b0, cfg_i.temp_high}) - $signed({1'b0, cfg_i.temp_low});
  assign abs_span = span[CFG_W] ? CFG_W'(-span) : span[CFG_W-1:0];
  assign diff     = $signed({1'b0, p1_q}) - $signed({1'b0, prod_q[PART_W-1:0]});
  assign abs_diff = diff[PART_W] ? PART_W'(-diff) : diff[PART_W-1:0];
  assign bat_n    = prod_q[MUL_W-1:0] + MUL_W'(BAT_ADD);
  assign trial    = {1'b0, num_q} - {1'b0, den_q};

  always_comb begin
    temp_wide = (neg_q ? -$signed({2'b00, quo_q}) : $signed({2'b00, quo_q}))
                + $signed((TEMP_W + 2)'(TEMP_OFFSET));
    priority if (invalid_q) begin
      temp_res = '0;
    end else if (ovf_q) begin
      temp_res = neg_q ? TEMP_MIN : TEMP_MAX;
    end else if (temp_wide[TEMP_W+1:TEMP_W-1] != {3{temp_wide[TEMP_W-1]}}) begin
      temp_res = temp_wide[TEMP_W+1] ? TEMP_MIN : TEMP_MAX;
    end else begin
      temp_res = temp_wide[TEMP_W-1:0];
    end
  end

  // Shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      BK_AVG0: begin mul_a = MUL_W'(sums_q[0]); mul_b = MUL_W'(AVG_RECIP); end
      BK_AVG1: begin mul_a = MUL_W'(sums_q[1]); mul_b = MUL_W'(AVG_RECIP); end
      BK_AVG2: begin mul_a = MUL_W'(sums_q[2]); mul_b = MUL_W'(AVG_RECIP); end
      BK_AVG3: begin mul_a = MUL_W'(sums_q[3]); mul_b = MUL_W'(AVG_RECIP); end
      BK_BAT0: begin mul_a = MUL_W'(avg_q[1]);  mul_b = MUL_W'(BAT_MUL);   end
      BK_BAT1: begin mul_a = bat_n;             mul_b = MUL_W'(BAT_RECIP); end
      BK_P1:   begin mul_a = MUL_W'(avg_q[2]);  mul_b = MUL_W'(cfg_i.vref_cal); end
      BK_P2:   begin mul_a = MUL_W'(avg_q[3]);  mul_b = MUL_W'(cfg_i.temp_low); end
      BK_MD:   begin mul_a = MUL_W'(avg_q[3]);  mul_b = MUL_W'(abs_span);  end
      BK_MN:   begin mul_a = MUL_W'(mag_q);     mul_b = MUL_W'(TEMP_GAIN); end
      default: begin mul_a = '0;                mul_b = '0;                end
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: if (pop_valid_i) state_d = BK_AVG0;
      BK_AVG0: state_d = BK_AVG1;
      BK_AVG1: state_d = BK_AVG2;
      BK_AVG2: state_d = BK_AVG3;
      BK_AVG3: state_d = BK_BAT0;
      BK_BAT0: state_d = BK_BAT1;
      BK_BAT1: state_d = BK_P1;
      BK_P1:   state_d = BK_P2;
      BK_P2:   state_d = BK_MD;
      BK_MD:   state_d = BK_MN;
      BK_MN:   state_d = BK_PREP;
      BK_PREP: state_d = BK_CHK;
      BK_CHK:  state_d = BK_DIV;
      BK_DIV:  if (cnt_q == '0) state_d = BK_FIN;
      BK_FIN:  if (out_free) state_d = BK_IDLE;
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == BK_CHK) begin
        cnt_q <= CNT_W'(QUO_W - 1);
      end else if (state_q == BK_DIV) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
      if (state_q == BK_FIN && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    unique case (state_q)
      BK_IDLE: if (pop_valid_i) sums_q <= pop_sums_i;
      BK_AVG1: avg_q[0] <= prod_q[AVG_SHIFT +: SAMPLE_W];
      BK_AVG2: avg_q[1] <= prod_q[AVG_SHIFT +: SAMPLE_W];
      BK_AVG3: avg_q[2] <= prod_q[AVG_SHIFT +: SAMPLE_W];
      BK_BAT0: avg_q[3] <= prod_q[AVG_SHIFT +: SAMPLE_W];
      BK_P1:   mv_q <= prod_q[BAT_SHIFT +: MV_W];
      BK_P2:   p1_q <= prod_q[PART_W-1:0];
      BK_MD: begin
        mag_q     <= abs_diff;
        neg_q     <= diff[PART_W] ^ span[CFG_W];
        invalid_q <= (avg_q[3] == '0) || (span == '0);
      end
      BK_MN:   md_q <= prod_q[PART_W-1:0];
      BK_PREP: begin
        num_q <= (NUM_W'(prod_q[PART_W+13:0]) << 1) + NUM_W'(md_q);
        den_q <= NUM_W'(md_q) << 1;
      end
      BK_CHK: begin
        ovf_q <= (num_q >= (den_q << QUO_W));
        den_q <= den_q << (QUO_W - 1);
        quo_q <= '0;
      end
      BK_DIV: begin
        if (!trial[NUM_W]) num_q <= trial[NUM_W-1:0];
        quo_q <= {quo_q[QUO_W-2:0], !trial[NUM_W]};
        den_q <= den_q >> 1;
      end
      BK_FIN: begin
        if (out_free) begin
          avg_out_q     <= avg_q[0];
          mv_out_q      <= mv_q;
          temp_out_q    <= temp_res;
          invalid_out_q <= invalid_q;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

/* design/multichannel_adc_average_scaler_top.sv */
// Top level of the four-channel ADC window averager with battery and temperature scaling.
//
//   channel   dir  handshake        payload
//   in_chan   in   valid / ready    current, battery, temp, vref samples (12 b each)
//   out_chan  out  valid / ready    current_avg, battery_millivolts, temp_centidegrees,
//                                   temp_invalid
//   cfg       in   cfg_we_i         cfg_index_i selects register, cfg_wdata_i value
//
// A scan is taken by the front end; the back end then makes 10 passes through
// the single 32x32 multiplier and runs a 16-step shift-subtract divider.
// The back end sequencer takes a new scan only when idle, once the last result is in the result register.
// A two-entry queue lets the front end take up to two scans ahead of the back end.
// History reads as zero until each slot has been written once; no clearing pass.
// The result register holds a finished result under stall while the next is computed.
module multichannel_adc_average_scaler_top #(
  parameter int unsigned WINDOW_DEPTH = 128
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  maas_in_if.sink                          in_chan,
  maas_out_if.source                       out_chan,
  input  logic                             cfg_we_i,
  input  logic [maas_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [maas_pkg::CFG_W-1:0]       cfg_wdata_i
);
  import maas_pkg::*;

  localparam int unsigned SUM_W = SAMPLE_W + $clog2(WINDOW_DEPTH);

  maas_cfg_t cfg_q;

  logic                           push_valid, push_ready;
  logic [CHANNELS-1:0][SUM_W-1:0] push_sums;
  logic                           pop_valid, pop_ready;
  logic [CHANNELS-1:0][SUM_W-1:0] pop_sums;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.vref_cal  <= VREF_CAL_RST;
      cfg_q.temp_low  <= TEMP_LOW_RST;
      cfg_q.temp_high <= TEMP_HIGH_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_VREF_CAL:  cfg_q.vref_cal  <= cfg_wdata_i;
        CFG_TEMP_LOW:  cfg_q.temp_low  <= cfg_wdata_i;
        CFG_TEMP_HIGH: cfg_q.temp_high <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  maas_front #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_chan      (in_chan),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_sums_o  (push_sums)
  );

  maas_queue #(
    .WIDTH (CHANNELS * SUM_W)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_sums),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_sums)
  );

  maas_back #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_sums_i  (pop_sums),
    .out_chan    (out_chan)
  );

endmodule

/* design/maas_checker.sv */
// Port-level checks of the ADC averager top level, attached by bind.
module maas_checker (
  input logic                                    clk_i,
  input logic                                    rst_ni,
  input logic                                    out_valid_i,
  input logic                                    out_ready_i,
  input logic [maas_pkg::SAMPLE_W-1:0]           current_avg_i,
  input logic [maas_pkg::MV_W-1:0]               battery_millivolts_i,
  input logic signed [maas_pkg::TEMP_W-1:0]      temp_centidegrees_i,
  input logic                                    temp_invalid_i
);
  import maas_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(current_avg_i) && $stable(battery_millivolts_i)
      && $stable(temp_centidegrees_i) && $stable(temp_invalid_i))
    else $error("result payload changed while stalled");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && temp_invalid_i |-> temp_centidegrees_i == '0)
    else $error("invalid temperature is not zero");

  a_mv_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> battery_millivolts_i <= MV_MAX)
    else $error("battery millivolts out of range");

endmodule

bind multichannel_adc_average_scaler_top maas_checker u_maas_checker (
  .clk_i                (clk_i),
  .rst_ni               (rst_ni),
  .out_valid_i          (out_chan.valid),
  .out_ready_i          (out_chan.ready),
  .current_avg_i        (out_chan.current_avg),
  .battery_millivolts_i (out_chan.battery_millivolts),
  .temp_centidegrees_i  (out_chan.temp_centidegrees),
  .temp_invalid_i       (out_chan.temp_invalid)
);

/* bench/tb_multichannel_adc_average_scaler_top.sv */
// Testbench of the ADC window averager: scans and calibration settings checked against a predictor.
`timescale 1ns / 100ps
module tb_multichannel_adc_average_scaler_top;
  import maas_pkg::*;

  localparam int unsigned WINDOW = 128;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned RANDOM_SEGMENTS = 8;
  localparam int unsigned DEAD_VREF_SEGMENT = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam longint MV_NUM = 485100;
  localparam longint MV_DEN = 192465;
  localparam longint MV_CAP = 16383;
  localparam longint GAIN = 8000;
  localparam longint OFFSET = 3000;
  localparam longint TEMP_HI = 32767;
  localparam longint TEMP_LO = -32768;

  typedef struct packed {
    logic [SAMPLE_W-1:0] current_sample;
    logic [SAMPLE_W-1:0] battery_sample;
    logic [SAMPLE_W-1:0] temp_sample;
    logic [SAMPLE_W-1:0] vref_sample;
  } scan_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0]      current_avg;
    logic [MV_W-1:0]          battery_millivolts;
    logic signed [TEMP_W-1:0] temp_centidegrees;
    logic                     temp_invalid;
  } reading_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_W-1:0]     cfg_wdata_i;

  maas_in_if  scan_chan();
  maas_out_if reading_chan();

  multichannel_adc_average_scaler_top #(
    .WINDOW_DEPTH(WINDOW)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_chan    (scan_chan),
    .out_chan   (reading_chan),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  scan_t               scan_q[$];
  reading_t            reading_q[$];
  maas_cfg_t           cal;
  logic [SAMPLE_W-1:0] history [WINDOW][CHANNELS];
  logic [18:0]         window_sum [CHANNELS];
  logic [6:0]          write_slot;
  int unsigned         send_idle_pct;
  int unsigned         recv_idle_pct;
  int unsigned         error_count;

  always #1 clk_i = ~clk_i;

  function automatic reading_t scale_scan(scan_t s);
    logic [SAMPLE_W-1:0] sample [CHANNELS];
    logic [SAMPLE_W-1:0] avg [CHANNELS];
    longint b, t, v, vcal, lo, span, num, den, mag_n, mag_d, q;
    bit neg;
    int c;
    reading_t r;
    sample[0] = s.current_sample;
    sample[1] = s.battery_sample;
    sample[2] = s.temp_sample;
    sample[3] = s.vref_sample;
    for (c = 0; c < CHANNELS; c++) begin
      window_sum[c] = window_sum[c] - 19'(history[write_slot][c]) + 19'(sample[c]);
      history[write_slot][c] = sample[c];
      avg[c] = SAMPLE_W'(window_sum[c] / WINDOW);
    end
    write_slot = write_slot + 7'd1;

    b = longint'(avg[1]);
    q = (2 * b * MV_NUM + MV_DEN) / (2 * MV_DEN);
    if (q > MV_CAP) q = MV_CAP;
    r.current_avg = avg[0];
    r.battery_millivolts = q[MV_W-1:0];

    t = longint'(avg[2]);
    v = longint'(avg[3]);
    vcal = longint'(cal.vref_cal);
    lo = longint'(cal.temp_low);
    span = longint'(cal.temp_high) - lo;
    if (v == 0 || span == 0) begin
      r.temp_invalid = 1'b1;
      r.temp_centidegrees = '0;
    end else begin
      num = GAIN * (t * vcal - lo * v);
      den = v * span;
      neg = (num < 0) != (den < 0);
      mag_n = (num < 0) ? -num : num;
      mag_d = (den < 0) ? -den : den;
      q = (2 * mag_n + mag_d) / (2 * mag_d);
      if (neg) q = -q;
      q = q + OFFSET;
      if (q > TEMP_HI) q = TEMP_HI;
      if (q < TEMP_LO) q = TEMP_LO;
      r.temp_invalid = 1'b0;
      r.temp_centidegrees = q[TEMP_W-1:0];
    end
    return r;
  endfunction

  // Drive scans: predict each transfer, then offer the next pending scan.
  always @(posedge clk_i) begin : drive_scans
    scan_t next_scan;
    if (!rst_ni) begin
      scan_chan.valid <= 1'b0;
    end else begin
      if (scan_chan.valid && scan_chan.ready) begin
        reading_q.push_back(scale_scan(scan_t'{scan_chan.current_sample,
                                               scan_chan.battery_sample,
                                               scan_chan.temp_sample,
                                               scan_chan.vref_sample}));
      end
      if (!scan_chan.valid || scan_chan.ready) begin
        if (scan_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_scan = scan_q.pop_front();
          scan_chan.current_sample <= next_scan.current_sample;
          scan_chan.battery_sample <= next_scan.battery_sample;
          scan_chan.temp_sample    <= next_scan.temp_sample;
          scan_chan.vref_sample    <= next_scan.vref_sample;
          scan_chan.valid          <= 1'b1;
        end else begin
          scan_chan.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : check_readings
    reading_t want;
    if (!rst_ni) begin
      reading_chan.ready <= 1'b0;
    end else begin
      if (reading_chan.valid && reading_chan.ready) begin
        if (reading_q.size() == 0) begin
          $display("%0t: unexpected reading, current_avg %0d", $time,
                   reading_chan.current_avg);
          error_count++;
        end else begin
          want = reading_q.pop_front();
          if (reading_chan.current_avg !== want.current_avg) begin
            $display("%0t: current_avg expected %0d, got %0d", $time,
                     want.current_avg, reading_chan.current_avg);
            error_count++;
          end
          if (reading_chan.battery_millivolts !== want.battery_millivolts) begin
            $display("%0t: battery_millivolts expected %0d, got %0d", $time,
                     want.battery_millivolts, reading_chan.battery_millivolts);
            error_count++;
          end
          if (reading_chan.temp_centidegrees !== want.temp_centidegrees) begin
            $display("%0t: temp_centidegrees expected %0d, got %0d", $time,
                     want.temp_centidegrees, reading_chan.temp_centidegrees);
            error_count++;
          end
          if (reading_chan.temp_invalid !== want.temp_invalid) begin
            $display("%0t: temp_invalid expected %0b, got %0b", $time,
                     want.temp_invalid, reading_chan.temp_invalid);
            error_count++;
          end
        end
      end
      reading_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_VREF_CAL:  cal.vref_cal = value;
      CFG_TEMP_LOW:  cal.temp_low = value;
      CFG_TEMP_HIGH: cal.temp_high = value;
      default: ;
    endcase
  endtask

  task automatic apply_cal(maas_cfg_t setting);
    write_reg(CFG_VREF_CAL, setting.vref_cal);
    write_reg(CFG_TEMP_LOW, setting.temp_low);
    write_reg(CFG_TEMP_HIGH, setting.temp_high);
    @(negedge clk_i);
  endtask

  // Hold until every scan is transferred and every reading has come back.
  task automatic wait_idle();
    do @(negedge clk_i);
    while (scan_q.size() != 0 || scan_chan.valid || reading_q.size() != 0);
  endtask

  function automatic void add_scan(logic [SAMPLE_W-1:0] cur, logic [SAMPLE_W-1:0] bat,
                                   logic [SAMPLE_W-1:0] tmp, logic [SAMPLE_W-1:0] vr);
    scan_q.push_back(scan_t'{cur, bat, tmp, vr});
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_code(int unsigned lo, int unsigned hi);
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2, 3:    return SAMPLE_W'($urandom_range(4095));
      default: return SAMPLE_W'($urandom_range(hi, lo));
    endcase
  endfunction

  function automatic maas_cfg_t random_cal();
    maas_cfg_t setting;
    setting.vref_cal  = pick_code(1400, 1700);
    setting.temp_low  = pick_code(850, 1050);
    setting.temp_high = pick_code(1100, 1300);
    if ($urandom_range(9) == 0) setting.temp_high = setting.temp_low;
    return setting;
  endfunction

  initial begin : timeout
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin : stimulus
    int seg;
    int k;
    int n;
    rst_ni                      = 1'b0;
    cfg_we_i                    = 1'b0;
    cfg_index_i                 = CFG_VREF_CAL;
    cfg_wdata_i                 = '0;
    scan_chan.valid             = 1'b0;
    scan_chan.current_sample    = '0;
    scan_chan.battery_sample    = '0;
    scan_chan.temp_sample       = '0;
    scan_chan.vref_sample       = '0;
    reading_chan.ready          = 1'b0;
    send_idle_pct               = 19;
    recv_idle_pct               = 47;
    error_count                 = 0;
    cal                         = '{VREF_CAL_RST, TEMP_LOW_RST, TEMP_HIGH_RST};
    write_slot                  = '0;
    for (k = 0; k < CHANNELS; k++) begin
      window_sum[k] = '0;
      for (n = 0; n < WINDOW; n++) history[n][k] = '0;
    end
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset calibration; zero reference average first.
    add_scan(12'd0, 12'd0, 12'd0, 12'd0);
    add_scan(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF);
    add_scan(12'hAAA, 12'h555, 12'hAAA, 12'h555);
    add_scan(12'h555, 12'hAAA, 12'h555, 12'hAAA);
    add_scan(12'hFFF, 12'hFFF, 12'd0, 12'hFFF);
    add_scan(12'd0, 12'hFFF, 12'hFFF, 12'd1);
    add_scan(12'd1, 12'd1, 12'd940, 12'd1500);
    add_scan(12'hFFF, 12'd0, 12'd1200, 12'd1500);
    wait_idle();

    // Drive temperature into positive saturation.
    apply_cal('{12'd4095, 12'd0, 12'd1});
    add_scan(12'hFFF, 12'hFFF, 12'hFFF, 12'd128);
    add_scan(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF);
    wait_idle();

    // Drive temperature into negative saturation.
    apply_cal('{12'd0, 12'd4094, 12'd4095});
    add_scan(12'd0, 12'd0, 12'd0, 12'hFFF);
    add_scan(12'd0, 12'd0, 12'hFFF, 12'hFFF);
    wait_idle();

    // Equal calibration codes.
    apply_cal('{12'd1500, 12'd2000, 12'd2000});
    add_scan(12'd100, 12'd200, 12'd1000, 12'd1500);
    add_scan(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF);
    wait_idle();

    // Reversed calibration span; unused register index must be ignored.
    apply_cal('{12'd1500, 12'd1200, 12'd940});
    write_reg(CFG_UNUSED, 12'hFFF);
    @(negedge clk_i);
    add_scan(12'd2048, 12'd2048, 12'd1000, 12'd1500);
    add_scan(12'd2048, 12'd2048, 12'd1300, 12'd1400);
    add_scan(12'd2048, 12'd2048, 12'd900, 12'd1600);
    wait_idle();

    for (seg = 0; seg < RANDOM_SEGMENTS; seg++) begin
      if (seg == 2) begin
        send_idle_pct = 47;
        recv_idle_pct = 19;
      end
      if (seg == 5) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      apply_cal(random_cal());
      n = (seg == DEAD_VREF_SEGMENT) ? 150 : 50;
      for (k = 0; k < n; k++) begin
        if (k == n / 2) wait_idle();
        add_scan(pick_code(0, 4095), pick_code(0, 4095), pick_code(850, 1350),
                 (seg == DEAD_VREF_SEGMENT) ? 12'd0 : pick_code(1350, 1750));
      end
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
